[src/mlf_pkg.sv]
// Shared widths, constants, control types and microprogram for the ladder filter.
`timescale 1ns / 1ps

package mlf_pkg;

  localparam int SAMPLE_WIDTH   = 24;
  localparam int STATE_WIDTH    = 32;
  localparam int COEF_FRAC_BITS = 16;

  localparam int CUTOFF_W   = COEF_FRAC_BITS + 1;
  localparam int FEEDBACK_W = COEF_FRAC_BITS + 2;
  localparam int F2_W       = COEF_FRAC_BITS + 2;
  localparam int F4_W       = COEF_FRAC_BITS + 4;
  localparam int OMF_W      = COEF_FRAC_BITS + 2;

  // 0.35013 and 0.3 in Q0.24
  localparam int K_W     = 24;
  localparam int K_SHIFT = 24;
  localparam logic [K_W-1:0] GAIN_K = K_W'(5874207);
  localparam logic [K_W-1:0] TAP_K  = K_W'(5033165);

  // shared multiplier operand and product widths
  localparam int MA_W = (STATE_WIDTH > F4_W + 1) ? STATE_WIDTH : F4_W + 1;
  localparam int MB_W = (F4_W + 1 > K_W + 1) ? F4_W + 1 : K_W + 1;
  localparam int P_W  = MA_W + MB_W;

  // three-term sums before saturation
  localparam int SUM_W = (STATE_WIDTH + 2 > SAMPLE_WIDTH) ? STATE_WIDTH + 2 : SAMPLE_WIDTH;

  localparam int POLES  = 4;
  localparam int POLE_W = 2;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_FF,        // f * f
    MUL_F2F2,      // f^2 * f^2
    MUL_F4K,       // f^4 * 0.35013
    MUL_FB,        // last pole output * fb
    MUL_G,         // stage * g
    MUL_TAP,       // pole input [k] * 0.3
    MUL_TAP_NEXT,  // pole input [k+1] * 0.3
    MUL_OMF        // pole output [k] * (1 - f)
  } mul_sel_t;

  // what to do with the product issued on the previous step
  typedef enum logic [2:0] {
    RET_NONE,
    RET_F2,
    RET_STAGE_FB,
    RET_F4,
    RET_G,
    RET_STAGE,
    RET_ACC,
    RET_POLE
  } ret_op_t;

  typedef struct packed {
    logic     load;
    mul_sel_t msel;
    logic     sh_k;
    ret_op_t  ret;
  } dp_ctrl_t;

  typedef struct packed {
    mul_sel_t msel;
    logic     sh_k;
    ret_op_t  ret;
    logic     jump;
    logic     fin;
  } ucode_t;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LOOP_STEP = STEP_W'(8);

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{msel: MUL_FF, sh_k: 1'b0, ret: RET_NONE, jump: 1'b0, fin: 1'b0};
    unique case (step)
      4'd0:  w.msel = MUL_FF;
      4'd1: begin w.msel = MUL_FB;   w.ret = RET_F2;       end
      4'd2: begin w.msel = MUL_F2F2; w.ret = RET_STAGE_FB; end
      4'd3:  w.ret = RET_F4;
      4'd4: begin w.msel = MUL_F4K;  w.sh_k = 1'b1;        end
      4'd5:  w.ret = RET_G;
      4'd6:  w.msel = MUL_G;
      4'd7: begin w.msel = MUL_TAP;  w.sh_k = 1'b1; w.ret = RET_STAGE; end
      4'd8: begin w.msel = MUL_OMF;  w.ret = RET_ACC;      end
      4'd9: begin
        w.msel = MUL_TAP_NEXT;
        w.sh_k = 1'b1;
        w.ret  = RET_POLE;
        w.jump = 1'b1;
      end
      default: w.fin = 1'b1;
    endcase
    return w;
  endfunction

  // saturate a wide sum to the state range
  function automatic logic signed [STATE_WIDTH-1:0] sat_state(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[STATE_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[STATE_WIDTH-1:0];
    end
    return v[STATE_WIDTH-1:0];
  endfunction

endpackage

[src/moog_ladder_lowpass_filter.sv]
// Top level of the four-pole resonant ladder low-pass filter: sequencer and handshakes.
`timescale 1ns / 1ps

// Four-pole resonant ladder low-pass filter. Each input word carries one signed
// Q1.23 sample, the cutoff coefficient f (unsigned Q1.16) and the resonance
// feedback fb (unsigned Q2.16); each yields one output word, the fourth-pole
// output saturated to Q1.23. Pole state is Q9.23 and saturates rather than
// wraps, so heavy resonance rings or clips but never folds over.
// Schedule: one shared 32x25 multiplier does all thirteen products (f^2, f^4,
// g, feedback, input scale and two per pole), one issued per step with the
// previous product rounded and retired in the same step. A short microprogram
// walks the coefficient chain in eight steps, then loops two steps per pole,
// then one step to hand the result to the output register. A new word is
// taken only once the block is back in IDLE, not while an item is in flight:
// in_stall is high throughout the run. A waiting result in the output register
// does not block acceptance, but the sequencer holds on its final step until
// the register is free.
// Reset clears the pole state to zero; no clearing pass is needed.

module moog_ladder_lowpass_filter (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [mlf_pkg::SAMPLE_WIDTH-1:0]  sample_in,
  input  logic        [mlf_pkg::CUTOFF_W-1:0]      cutoff_coef,
  input  logic        [mlf_pkg::FEEDBACK_W-1:0]    feedback_gain,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [mlf_pkg::SAMPLE_WIDTH-1:0]  sample_out
);
  import mlf_pkg::*;

  typedef enum logic {
    IDLE,
    RUN
  } seq_state_t;

  seq_state_t                     state;
  logic        [STEP_W-1:0]       step;
  ucode_t                         uw;
  dp_ctrl_t                       dp_ctrl;
  logic                           accept;
  logic                           out_free;
  logic                           last_pole;
  logic signed [SAMPLE_WIDTH-1:0] smp_sat;

  // control word for the current step
  assign uw = ucode_rom(step);

  assign in_stall = (state != IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // retire actions only while running, so a held final step repeats nothing
  always_comb begin
    dp_ctrl.load = accept;
    dp_ctrl.msel = uw.msel;
    dp_ctrl.sh_k = uw.sh_k;
    dp_ctrl.ret  = (state == RUN) ? uw.ret : RET_NONE;
  end

  mlf_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (dp_ctrl),
    .sample_in     (sample_in),
    .cutoff_coef   (cutoff_coef),
    .feedback_gain (feedback_gain),
    .last_pole     (last_pole),
    .smp_sat       (smp_sat)
  );

  // sequencer: step counter with a conditional jump back over the pole loop
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      // a word taken on the final step is replaced by the new one below
      if (out_valid && !out_stall && !(state == RUN && uw.fin)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            state <= RUN;
            step  <= '0;
          end
        end
        RUN: begin
          if (uw.fin) begin
            if (out_free) begin
              sample_out <= smp_sat;
              out_valid  <= 1'b1;
              state      <= IDLE;
            end
          end else if (uw.jump && !last_pole) begin
            step <= LOOP_STEP;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[src/mlf_datapath.sv]
// Ladder filter datapath: shared multiplier, rounding, pole state and working registers.
`timescale 1ns / 1ps

module mlf_datapath (
  input  logic                                      clk,
  input  logic                                      rst,
  input  mlf_pkg::dp_ctrl_t                         ctrl,
  input  logic signed [mlf_pkg::SAMPLE_WIDTH-1:0]   sample_in,
  input  logic        [mlf_pkg::CUTOFF_W-1:0]       cutoff_coef,
  input  logic        [mlf_pkg::FEEDBACK_W-1:0]     feedback_gain,
  output logic                                      last_pole,
  output logic signed [mlf_pkg::SAMPLE_WIDTH-1:0]   smp_sat
);
  import mlf_pkg::*;

  localparam int OUT_EXT_W = (STATE_WIDTH > SAMPLE_WIDTH) ? STATE_WIDTH : SAMPLE_WIDTH;
  localparam logic signed [P_W-1:0] H_CF = P_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [P_W-1:0] H_K  = P_W'(1) << (K_SHIFT - 1);
  localparam logic signed [P_W-1:0] ST_MAX_P =
    {{(P_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [P_W-1:0] ST_MIN_P = ~ST_MAX_P;
  localparam logic signed [OUT_EXT_W-1:0] SMP_MAX =
    {{(OUT_EXT_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [OUT_EXT_W-1:0] SMP_MIN = ~SMP_MAX;
  localparam logic [OMF_W-1:0] ONE_Q = OMF_W'(1) << COEF_FRAC_BITS;

  logic signed [STATE_WIDTH-1:0] pin  [POLES];
  logic signed [STATE_WIDTH-1:0] pout [POLES];
  logic        [POLE_W-1:0]      k;

  logic signed [STATE_WIDTH-1:0] x;
  logic        [CUTOFF_W-1:0]    f;
  logic        [FEEDBACK_W-1:0]  fb;
  logic        [F2_W-1:0]        f2;
  logic        [F4_W-1:0]        f4;
  logic        [F4_W-1:0]        g;
  logic signed [STATE_WIDTH-1:0] stage;
  logic signed [STATE_WIDTH:0]   acc;
  logic signed [P_W-1:0]         prod;
  logic                          prod_sh_k;

  logic        [POLE_W-1:0]      pin_idx;
  logic        [POLE_W-1:0]      pout_idx;
  logic signed [STATE_WIDTH-1:0] pin_rd;
  logic signed [STATE_WIDTH-1:0] pout_rd;
  logic signed [OMF_W-1:0]       omf;
  logic signed [MA_W-1:0]        ma;
  logic signed [MB_W-1:0]        mb;
  logic signed [P_W-1:0]         mul;
  logic signed [P_W-1:0]         rsum;
  logic signed [P_W-1:0]         rq;
  logic signed [STATE_WIDTH-1:0] rv;
  logic signed [SUM_W-1:0]       pole_sum;
  logic signed [SUM_W-1:0]       fb_diff;
  logic signed [STATE_WIDTH-1:0] pole_sat;
  logic signed [OUT_EXT_W-1:0]   out_ext;

  // one read port per state array
  assign pin_idx  = (ctrl.msel == MUL_TAP_NEXT) ? k + POLE_W'(1) : k;
  assign pout_idx = (ctrl.msel == MUL_FB) ? POLE_W'(POLES - 1) : k;
  assign pin_rd   = pin[pin_idx];
  assign pout_rd  = pout[pout_idx];
  assign omf      = ONE_Q - {1'b0, f};

  always_comb begin
    unique case (ctrl.msel)
      MUL_FF: begin
        ma = MA_W'(f);
        mb = MB_W'(f);
      end
      MUL_F2F2: begin
        ma = MA_W'(f2);
        mb = MB_W'(f2);
      end
      MUL_F4K: begin
        ma = MA_W'(f4);
        mb = MB_W'(GAIN_K);
      end
      MUL_FB: begin
        ma = MA_W'(pout_rd);
        mb = MB_W'(fb);
      end
      MUL_G: begin
        ma = MA_W'(stage);
        mb = MB_W'(g);
      end
      MUL_TAP, MUL_TAP_NEXT: begin
        ma = MA_W'(pin_rd);
        mb = MB_W'(TAP_K);
      end
      MUL_OMF: begin
        ma = MA_W'(pout_rd);
        mb = MB_W'(omf);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mul = ma * mb;

  // round half away from zero, then saturate to the state range
  always_comb begin
    rsum = prod + (prod_sh_k ? H_K : H_CF) - {{(P_W-1){1'b0}}, prod[P_W-1]};
    rq   = prod_sh_k ? (rsum >>> K_SHIFT) : (rsum >>> COEF_FRAC_BITS);
    if (rq > ST_MAX_P) begin
      rv = ST_MAX_P[STATE_WIDTH-1:0];
    end else if (rq < ST_MIN_P) begin
      rv = ST_MIN_P[STATE_WIDTH-1:0];
    end else begin
      rv = rq[STATE_WIDTH-1:0];
    end
  end

  assign pole_sum = SUM_W'(acc) + SUM_W'(rv);
  assign fb_diff  = SUM_W'(x) - SUM_W'(rv);
  assign pole_sat = sat_state(pole_sum);

  assign last_pole = (k == POLE_W'(POLES - 1));

  always_comb begin
    out_ext = OUT_EXT_W'(pout[POLES-1]);
    if (out_ext > SMP_MAX) begin
      smp_sat = SMP_MAX[SAMPLE_WIDTH-1:0];
    end else if (out_ext < SMP_MIN) begin
      smp_sat = SMP_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      smp_sat = out_ext[SAMPLE_WIDTH-1:0];
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POLES; i++) begin
        pin[i]  <= '0;
        pout[i] <= '0;
      end
      k <= '0;
    end else begin
      if (ctrl.load) begin
        k <= '0;
      end else if (ctrl.ret == RET_POLE) begin
        pout[k] <= pole_sat;
        pin[k]  <= stage;
        k       <= k + POLE_W'(1);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod      <= mul;
    prod_sh_k <= ctrl.sh_k;
    if (ctrl.load) begin
      x  <= sat_state(SUM_W'(sample_in));
      f  <= cutoff_coef;
      fb <= feedback_gain;
    end
    unique case (ctrl.ret)
      RET_NONE:     ;
      RET_F2:       f2    <= rv[F2_W-1:0];
      RET_STAGE_FB: stage <= sat_state(fb_diff);
      RET_F4:       f4    <= rv[F4_W-1:0];
      RET_G:        g     <= rv[F4_W-1:0];
      RET_STAGE:    stage <= rv;
      RET_ACC:      acc   <= (STATE_WIDTH+1)'(stage) + (STATE_WIDTH+1)'(rv);
      RET_POLE:     stage <= pole_sat;
      default:      ;
    endcase
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the four-pole ladder low-pass filter.
`timescale 1ns / 1ps

module tb;

  import mlf_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int STW = STATE_WIDTH;
  localparam int CFB = COEF_FRAC_BITS;
  localparam int CW  = CUTOFF_W;
  localparam int FW  = FEEDBACK_W;

  // 0.35013 and 0.3 in Q0.24
  localparam longint GAIN_Q24 = 5874207;
  localparam longint TAP_Q24  = 5033165;

  localparam int RANDOM_WORDS = 750;
  localparam int DRAIN_CYCLES = 40;

  localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [CW-1:0] F_ONE = CW'(1) << CFB;
  localparam logic [CW-1:0] F_MAX = '1;
  localparam logic [FW-1:0] FB_MAX = '1;

  // Bit-accurate ladder predictor plus the queue of samples still owed by the block.
  class ladder_scoreboard;
    longint pole_in[4];
    longint pole_out[4];
    logic signed [SW-1:0] owed_q[$];
    int errors = 0;
    int words_out = 0;

    function longint clip(longint v, int w);
      longint hi;
      hi = (longint'(1) << (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // round(a*b / 2^s) half away from zero, clipped to the state range
    function longint mul_round(longint a, longint b, int s);
      bit neg;
      longint ma;
      longint mb;
      longint q;
      longint lim;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      q   = (ma * mb + (longint'(1) << (s - 1))) >>> s;
      lim = neg ? (longint'(1) << (STW - 1)) : (longint'(1) << (STW - 1)) - 1;
      if (q > lim) q = lim;
      return neg ? -q : q;
    endfunction

    function void note_input(logic signed [SW-1:0] s, logic [CW-1:0] f, logic [FW-1:0] fb);
      longint x;
      longint f2;
      longint f4;
      longint g;
      longint omf;
      longint stage;
      longint sum;
      x     = clip(longint'(s), STW);
      f2    = (longint'(f) * longint'(f) + (longint'(1) << (CFB - 1))) >>> CFB;
      f4    = (f2 * f2 + (longint'(1) << (CFB - 1))) >>> CFB;
      g     = (f4 * GAIN_Q24 + (longint'(1) << 23)) >>> 24;
      omf   = (longint'(1) << CFB) - longint'(f);
      stage = clip(x - mul_round(pole_out[3], longint'(fb), CFB), STW);
      stage = mul_round(stage, g, CFB);
      for (int k = 0; k < 4; k++) begin
        sum = stage + mul_round(pole_in[k], TAP_Q24, 24) + mul_round(pole_out[k], omf, CFB);
        pole_in[k]  = stage;
        pole_out[k] = clip(sum, STW);
        stage       = pole_out[k];
      end
      owed_q.push_back(SW'(clip(pole_out[3], SW)));
    endfunction

    task report_mismatch(string what, longint got, longint want);
      errors++;
      $display("%0t mismatch on output word %0d: %s got %0d want %0d",
               $realtime, words_out, what, got, want);
    endtask

    task check_result(logic signed [SW-1:0] got);
      logic signed [SW-1:0] want;
      if (owed_q.size() == 0) begin
        report_mismatch("unexpected word, sample_out", longint'(got), 0);
      end else begin
        want = owed_q.pop_front();
        if (got !== want) report_mismatch("sample_out", longint'(got), longint'(want));
      end
      words_out++;
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [SW-1:0] sample_in;
  logic [CW-1:0]        cutoff_coef;
  logic [FW-1:0]        feedback_gain;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [SW-1:0] sample_out;

  ladder_scoreboard sb;

  moog_ladder_lowpass_filter u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample_in     (sample_in),
    .cutoff_coef   (cutoff_coef),
    .feedback_gain (feedback_gain),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_out    (sample_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop. Slowest honest run is roughly 800 words, each with busy time, gap and
  // output stall, about 0.56 ms at 12 ns; this allows several times that.
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Present one word and hold it, payload steady, until the block takes it.
  // Valid is left high so a following word in the same burst goes straight on.
  task automatic send_word(input logic signed [SW-1:0] s, input logic [CW-1:0] f,
                           input logic [FW-1:0] fb);
    in_valid      <= 1'b1;
    sample_in     <= s;
    cutoff_coef   <= f;
    feedback_gain <= fb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(s, f, fb);
  endtask

  // Random words. Save for rare corner f values, a tame burst keeps f at or under one
  // and fb moderate to keep the ladder linear; a wild burst uses full field ranges.
  task automatic random_word(input bit tame, output logic signed [SW-1:0] s,
                             output logic [CW-1:0] f, output logic [FW-1:0] fb);
    int pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0:       s = SMP_MAX;
      1:       s = SMP_MIN;
      2:       s = '0;
      default: s = SW'($urandom);
    endcase
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0:       f = '0;
        1:       f = F_ONE;
        2:       f = F_MAX;
        default: f = CW'(1);
      endcase
    end else if (tame) begin
      f = CW'($urandom_range(0, 65536));
    end else begin
      f = CW'($urandom_range(0, 131071));
    end
    if (tame) begin
      fb = FW'($urandom_range(0, 150000));
    end else begin
      case ($urandom_range(0, 3))
        0:       fb = FB_MAX;
        1:       fb = FW'($urandom_range(200000, 262143));
        default: fb = FW'($urandom_range(0, 262143));
      endcase
    end
  endtask

  // Output-side back-pressure: short stall runs between longer free-running runs.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left == 0) begin
      if ($urandom_range(0, 9) < 3) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(1, 10);
      end else begin
        out_stall  <= 1'b0;
        stall_left = $urandom_range(1, 40);
      end
    end else begin
      stall_left--;
    end
  end

  // Every word the block hands over is checked against the oldest owed sample.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(sample_out);
  end

  initial begin
    logic signed [SW-1:0] s;
    logic [CW-1:0]        f;
    logic [FW-1:0]        fb;
    int                   sent;
    int                   burst;
    int                   gap;
    bit                   tame;

    rst           = 1'b1;
    in_valid      = 1'b0;
    sample_in     = '0;
    cutoff_coef   = '0;
    feedback_gain = '0;
    sb            = new;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words, back to back.
    send_word('0, '0, '0);
    send_word(SMP_MAX, F_ONE, '0);
    send_word(SMP_MIN, F_ONE, '0);
    // zero cutoff: g is zero, so no input reaches the poles
    send_word(SMP_MAX, '0, '0);
    send_word(SMP_MIN, '0, FB_MAX);
    // cutoff above one: 1-f goes negative
    repeat (3) send_word(SMP_MAX, F_MAX, '0);
    repeat (3) send_word(SMP_MIN, F_MAX, FB_MAX);
    // heavy resonance: the loop rings and the state clips rather than wrapping
    repeat (5) send_word(SMP_MAX, CW'(40000), FB_MAX);
    for (int i = 0; i < 4; i++) send_word(i[0] ? SMP_MIN : SMP_MAX, F_ONE, FB_MAX);
    send_word('0, CW'(1), FW'(1));
    send_word(SW'(1), CW'(20000), FW'(65536));
    send_word(SW'(-1), CW'(20000), FW'(65536));

    // Random bursts with random gaps; the regime is chosen per burst.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 12);
      tame  = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < burst; i++) begin
        random_word(tame, s, f, fb);
        send_word(s, f, fb);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk);
    // a little longer, so a stray extra word would still be caught
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/mlf_pkg.sv
src/mlf_datapath.sv
src/moog_ladder_lowpass_filter.sv
tb/tb.sv
